// ===== hdl/scc_pkg.sv =====
package scc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned RawW  = 16;
  localparam int unsigned PosW  = 3;
  localparam int unsigned TempW = 15;
  localparam int unsigned HumW  = 14;
  localparam int unsigned ScaleW = 15;
  localparam int unsigned ProdW = RawW + ScaleW;

  localparam logic [ByteW-1:0]  CrcPoly    = 8'h31;
  localparam logic [ByteW-1:0]  CrcInit    = 8'h00;
  localparam logic [ScaleW-1:0] TempScale  = 15'd16500;
  localparam logic [ScaleW-1:0] HumScale   = 15'd10000;
  localparam logic [16:0]       Divisor    = 17'd65535;
  localparam logic [TempW-1:0]  TempOffset = 15'd4000;

  // Frame byte positions
  localparam logic [PosW-1:0] PosTempHi  = 3'd0;
  localparam logic [PosW-1:0] PosTempLo  = 3'd1;
  localparam logic [PosW-1:0] PosTempCrc = 3'd2;
  localparam logic [PosW-1:0] PosHumHi   = 3'd3;
  localparam logic [PosW-1:0] PosHumLo   = 3'd4;
  localparam logic [PosW-1:0] PosHumCrc  = 3'd5;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_ERR = 2'd1,
    STATUS_HUM_ERR  = 2'd2
  } status_e;

  // Work handed from the byte front end to the scaling back end
  typedef struct packed {
    logic              is_hum;
    status_e           status;
    logic [RawW-1:0]   raw;
  } job_t;

  // MSB-first CRC-8 over one byte
  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] b);
    logic [ByteW-1:0] v;
    v = crc ^ b;
    for (int i = 0; i < ByteW; i++) begin
      if (v[ByteW-1]) begin
        v = {v[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[ByteW-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ===== hdl/scc_front.sv =====
module scc_front
  import scc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             frame_start_i,
  input  logic             full_i,
  output logic             push_o,
  output job_t             job_o
);

  logic [PosW-1:0]  pos_q, pos_d, pos;
  logic [ByteW-1:0] crc_q, crc_d;
  logic [RawW-1:0]  raw_q, raw_d;
  logic             tbad_q, tbad_d;
  logic             accept;
  logic             crc_match;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign crc_match  = (rx_byte_i == crc_q);

  always_comb begin
    pos = frame_start_i ? PosTempHi : pos_q;
    if (pos > PosHumCrc) begin
      pos = PosTempHi;
    end
    pos_d         = pos_q;
    crc_d         = crc_q;
    raw_d         = raw_q;
    tbad_d        = tbad_q;
    push_o        = 1'b0;
    job_o.is_hum  = 1'b0;
    job_o.status  = STATUS_OK;
    job_o.raw     = raw_q;
    if (accept) begin
      pos_d = (pos >= PosHumCrc) ? PosTempHi : pos + 3'd1;
      case (pos)
        PosTempHi, PosHumHi: begin
          crc_d = crc8_update(CrcInit, rx_byte_i);
          raw_d = {rx_byte_i, 8'h00};
        end
        PosTempLo, PosHumLo: begin
          crc_d = crc8_update(crc_q, rx_byte_i);
          raw_d = {raw_q[RawW-1:ByteW], rx_byte_i};
        end
        PosTempCrc: begin
          tbad_d       = !crc_match;
          push_o       = 1'b1;
          job_o.status = crc_match ? STATUS_OK : STATUS_TEMP_ERR;
        end
        default: begin
          push_o       = 1'b1;
          job_o.is_hum = 1'b1;
          if (tbad_q) begin
            job_o.status = STATUS_TEMP_ERR;
          end else if (!crc_match) begin
            job_o.status = STATUS_HUM_ERR;
          end else begin
            job_o.status = STATUS_OK;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      crc_q  <= CrcInit;
      raw_q  <= '0;
      tbad_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      raw_q  <= raw_d;
      tbad_q <= tbad_d;
    end
  end

endmodule

// ===== hdl/scc_queue.sv =====
module scc_queue
  import scc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !(pop_i && valid_o)) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i && valid_o) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

endmodule

// ===== hdl/scc_back.sv =====
module scc_back
  import scc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    job_valid_i,
  input  job_t                    job_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [TempW-1:0] temperature_centi_o,
  output logic [HumW-1:0]         humidity_centi_o,
  output logic [1:0]              status_o
);

  logic             advance;
  logic             s1_valid_q;
  logic             s1_hum_q;
  status_e          s1_status_q;
  logic [ProdW-1:0] s1_prod_q;

  logic [ScaleW-1:0] quot_hi;
  logic [16:0]       rem;
  logic [ScaleW-1:0] quot;
  logic [TempW-1:0]  temp_val;

  logic [TempW-1:0] stored_temp_q;
  logic [HumW-1:0]  stored_hum_q;

  logic             out_valid_q;
  logic [TempW-1:0] out_temp_q;
  logic [HumW-1:0]  out_hum_q;
  status_e          out_status_q;

  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = job_valid_i && advance;

  // Divide by 65535: x = hi*65536 + lo, remainder lo + hi stays below twice the divisor
  assign quot_hi  = s1_prod_q[ProdW-1:16];
  assign rem      = {1'b0, s1_prod_q[15:0]} + {2'b00, quot_hi};
  assign quot     = quot_hi + ((rem >= Divisor) ? 15'd1 : 15'd0);
  assign temp_val = quot - TempOffset;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_hum_q    <= job_i.is_hum;
      s1_status_q <= job_i.status;
      s1_prod_q   <= ProdW'(job_i.raw) * ProdW'(job_i.is_hum ? HumScale : TempScale);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q && s1_hum_q) begin
      out_temp_q   <= stored_temp_q;
      out_hum_q    <= (s1_status_q == STATUS_OK) ? quot[HumW-1:0] : stored_hum_q;
      out_status_q <= s1_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      stored_temp_q <= '0;
      stored_hum_q  <= '0;
    end else if (advance) begin
      s1_valid_q  <= job_valid_i;
      out_valid_q <= s1_valid_q && s1_hum_q;
      if (s1_valid_q && (s1_status_q == STATUS_OK)) begin
        if (s1_hum_q) begin
          stored_hum_q <= quot[HumW-1:0];
        end else begin
          stored_temp_q <= temp_val;
        end
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign temperature_centi_o = signed'(out_temp_q);
  assign humidity_centi_o    = out_hum_q;
  assign status_o            = out_status_q;

endmodule

// ===== hdl/sensor_frame_crc_check_and_scale.sv =====
// Sensor frame CRC check and scale.
// Input channel (in_valid_i / in_stall_o) carries one frame byte per beat:
// temperature high, low, CRC-8, humidity high, low, CRC-8. frame_start_i marks
// byte 0 and drops any partial frame. CRC-8 is poly 0x31, init 0, MSB first.
// Output channel (out_valid_o / out_stall_i) carries one beat per frame after
// its sixth byte: stored temperature (0.01 C), stored humidity (0.01 %RH) and
// status (0 ok, 1 temperature CRC error, 2 humidity CRC error).
// Throughput: one byte per cycle while out_stall_i is low. The front end
// checks CRCs and hands two scaling jobs per frame into a two-entry queue;
// the back end runs a constant multiply stage and a divide-by-65535
// correction stage, one job per cycle unless stalled. The sixth byte's job
// passes the queue, the multiply stage and the output register to its result.
// Reset clears the byte position, CRC, stored values and all valid flags.
// A stalled result holds the back end; once the queue holds two jobs,
// in_stall_o rises and every byte waits until the back end pops a job.
module sensor_frame_crc_check_and_scale
  import scc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [ByteW-1:0]        rx_byte_i,
  input  logic                    frame_start_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [TempW-1:0] temperature_centi_o,
  output logic [HumW-1:0]         humidity_centi_o,
  output logic [1:0]              status_o
);

  logic push, full, pop, job_valid;
  job_t push_job, pop_job;

  // Byte front end: position tracking, CRC, raw word assembly
  scc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .full_i        (full),
    .push_o        (push),
    .job_o         (push_job)
  );

  // Decouple byte intake from scaling
  scc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (pop_job)
  );

  // Scale, update stored values, drive result beats
  scc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .job_valid_i         (job_valid),
    .job_i               (pop_job),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .temperature_centi_o (temperature_centi_o),
    .humidity_centi_o    (humidity_centi_o),
    .status_o            (status_o)
  );

endmodule
